// ===== src/fp16_broadcast_sub_div_macros.svh =====
// Assertion macros used by the top-level file to check this block.
`ifndef FP16_BROADCAST_SUB_DIV_MACROS_SVH
`define FP16_BROADCAST_SUB_DIV_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FBSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FBSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fbsd_pkg.sv =====
package fbsd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_OPCODE     = 2'd0;
    localparam logic [1:0] CFG_BROADCAST  = 2'd1;
    localparam logic [1:0] CFG_ROW_LENGTH = 2'd2;
    localparam logic [1:0] CFG_ROW_COUNT  = 2'd3;

    localparam logic OP_SUB = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam logic [15:0] QNAN16  = 16'h7E00;
    localparam logic [14:0] INF_MAG = 15'h7C00;

    typedef struct packed {
        logic [15:0] a_value;
        logic [15:0] b_value;
        logic        op;
        logic        row_end;
        logic        task_end;
    } item_t;

endpackage

// ===== src/fbsd_front.sv =====
module fbsd_front
    import fbsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] a_value,
    input  logic [15:0] b_value,
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic        opcode_reg;
    logic        broadcast_reg;
    logic [15:0] row_length_reg;
    logic [15:0] row_count_reg;
    logic [15:0] column_reg;
    logic [15:0] row_reg;
    logic [15:0] scalar_reg;

    logic [15:0] len;
    logic [15:0] cnt;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic        rend;
    logic        tend;
    logic        accept;

    always_comb
    begin
        len     = (row_length_reg == 16'd0) ? 16'd1 : row_length_reg;
        cnt     = (row_count_reg == 16'd0) ? 16'd1 : row_count_reg;
        col_inc = {1'b0, column_reg} + 17'd1;
        row_inc = {1'b0, row_reg} + 17'd1;
        rend    = col_inc >= {1'b0, len};
        tend    = rend && (row_inc >= {1'b0, cnt});
        accept  = in_valid && push_ready;
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_item.a_value  = a_value;
        push_item.b_value  = (broadcast_reg && column_reg != 16'd0) ? scalar_reg : b_value;
        push_item.op       = opcode_reg;
        push_item.row_end  = rend;
        push_item.task_end = tend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg     <= OP_SUB;
            broadcast_reg  <= 1'b0;
            row_length_reg <= 16'd1;
            row_count_reg  <= 16'd1;
            column_reg     <= 16'd0;
            row_reg        <= 16'd0;
            scalar_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_OPCODE:     opcode_reg     <= cfg_data[0];
                    CFG_BROADCAST:  broadcast_reg  <= cfg_data[0];
                    CFG_ROW_LENGTH: row_length_reg <= cfg_data;
                    CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                    default:        opcode_reg     <= opcode_reg;
                endcase
            end
            if (accept)
            begin
                if (column_reg == 16'd0)
                begin
                    scalar_reg <= b_value;
                end
                if (rend)
                begin
                    column_reg <= 16'd0;
                    row_reg    <= tend ? 16'd0 : row_inc[15:0];
                end
                else
                begin
                    column_reg <= col_inc[15:0];
                end
            end
        end
    end

endmodule

// ===== src/fbsd_queue.sv =====
module fbsd_queue
    import fbsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/fbsd_back.sv =====
module fbsd_back
    import fbsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  item_t       pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] y_value,
    output logic        row_end,
    output logic        task_end
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ADD,
        ST_NORM,
        ST_DIV,
        ST_DIVN,
        ST_ROUND,
        ST_OUT
    } state_t;

    function automatic logic [3:0] lead_zeros11(input logic [10:0] v);
        logic [3:0] n;
        n = 4'd11;
        for (int i = 0; i < 11; i++)
        begin
            if (v[i])
            begin
                n = 4'(10 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] msb_pos15(input logic [14:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 15; i++)
        begin
            if (v[i])
            begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [15:0] round_fp16(input logic sign, input logic signed [7:0] expo,
                                               input logic [13:0] sig, input logic sticky);
        logic [7:0]  sh;
        logic [13:0] s2;
        logic        st;
        logic [10:0] m;
        logic        inc;
        logic [7:0]  base;
        logic [17:0] bits;
        logic [15:0] res;
        sh = 8'd1 - expo;
        if (expo > 8'sd0)
        begin
            s2   = sig;
            st   = sticky;
            base = expo - 8'sd1;
        end
        else
        begin
            base = 8'd0;
            if (sh >= 8'd14)
            begin
                s2 = 14'd0;
                st = sticky | (|sig);
            end
            else
            begin
                s2 = sig >> sh[3:0];
                st = sticky | (|(sig & ((14'd1 << sh[3:0]) - 14'd1)));
            end
        end
        m    = s2[13:3];
        st   = st | (|s2[1:0]);
        inc  = s2[2] & (st | m[0]);
        bits = {base, 10'd0} + {7'd0, m} + {17'd0, inc};
        if (expo >= 8'sd31 || bits >= 18'h07C00)
        begin
            res = {sign, INF_MAG};
        end
        else
        begin
            res = {sign, bits[14:0]};
        end
        return res;
    endfunction

    state_t             state_reg;
    logic [15:0]        a_reg;
    logic [15:0]        b_reg;
    logic               op_reg;
    logic               rend_reg;
    logic               tend_reg;
    logic [14:0]        x_reg;
    logic [13:0]        y_reg;
    logic signed [7:0]  expo_reg;
    logic               sign_reg;
    logic               add_reg;
    logic               sticky_reg;
    logic [15:0]        q_reg;
    logic [2:0]         cnt_reg;
    logic [15:0]        result_reg;
    logic               out_valid_reg;
    logic [15:0]        y_value_reg;
    logic               row_end_reg;
    logic               task_end_reg;

    logic [4:0]         a_exp;
    logic [4:0]         b_exp;
    logic [10:0]        a_man;
    logic [10:0]        b_man;
    logic [4:0]         a_eff;
    logic [4:0]         b_eff;
    logic               a_nan;
    logic               b_nan;
    logic               a_inf;
    logic               b_inf;
    logic               a_zero;
    logic               b_zero;
    logic               sub_b_sign;
    logic               div_sign;
    logic               prep_special;
    logic [15:0]        prep_value;
    logic               a_big;
    logic [4:0]         big_e;
    logic [4:0]         small_e;
    logic [10:0]        big_m;
    logic [10:0]        small_m;
    logic               big_s;
    logic               small_s;
    logic [4:0]         diff;
    logic [13:0]        small_ext;
    logic [13:0]        aligned;
    logic               lost;
    logic [3:0]         a_lz;
    logic [3:0]         b_lz;
    logic [10:0]        a_norm;
    logic [10:0]        b_norm;
    logic signed [7:0]  div_expo;

    logic [14:0]        add_res;

    logic [3:0]         msb;
    logic [3:0]         lsh;
    logic [13:0]        n_sig;
    logic signed [7:0]  n_expo;
    logic               n_st;

    logic [11:0]        r0;
    logic [11:0]        r1;
    logic [11:0]        r2;
    logic [11:0]        t1;
    logic [11:0]        t2;
    logic               bit1;
    logic               bit2;

    logic [13:0]        d_sig;
    logic signed [7:0]  d_expo;
    logic               d_st;

    always_comb
    begin
        a_exp      = a_reg[14:10];
        b_exp      = b_reg[14:10];
        a_man      = {a_exp != 5'd0, a_reg[9:0]};
        b_man      = {b_exp != 5'd0, b_reg[9:0]};
        a_eff      = (a_exp == 5'd0) ? 5'd1 : a_exp;
        b_eff      = (b_exp == 5'd0) ? 5'd1 : b_exp;
        a_nan      = (a_exp == 5'h1F) && (a_reg[9:0] != 10'd0);
        b_nan      = (b_exp == 5'h1F) && (b_reg[9:0] != 10'd0);
        a_inf      = a_reg[14:0] == INF_MAG;
        b_inf      = b_reg[14:0] == INF_MAG;
        a_zero     = a_reg[14:0] == 15'd0;
        b_zero     = b_reg[14:0] == 15'd0;
        sub_b_sign = ~b_reg[15];
        div_sign   = a_reg[15] ^ b_reg[15];

        prep_special = 1'b0;
        prep_value   = QNAN16;
        if (a_nan || b_nan)
        begin
            prep_special = 1'b1;
        end
        else if (op_reg == OP_SUB)
        begin
            if (a_inf && b_inf)
            begin
                prep_special = 1'b1;
                prep_value   = (a_reg[15] == sub_b_sign) ? {a_reg[15], INF_MAG} : QNAN16;
            end
            else if (a_inf)
            begin
                prep_special = 1'b1;
                prep_value   = {a_reg[15], INF_MAG};
            end
            else if (b_inf)
            begin
                prep_special = 1'b1;
                prep_value   = {sub_b_sign, INF_MAG};
            end
        end
        else
        begin
            if ((a_zero && b_zero) || (a_inf && b_inf))
            begin
                prep_special = 1'b1;
            end
            else if (b_zero || a_inf)
            begin
                prep_special = 1'b1;
                prep_value   = {div_sign, INF_MAG};
            end
            else if (b_inf || a_zero)
            begin
                prep_special = 1'b1;
                prep_value   = {div_sign, 15'd0};
            end
        end

        a_big     = a_reg[14:0] >= b_reg[14:0];
        big_e     = a_big ? a_eff : b_eff;
        small_e   = a_big ? b_eff : a_eff;
        big_m     = a_big ? a_man : b_man;
        small_m   = a_big ? b_man : a_man;
        big_s     = a_big ? a_reg[15] : sub_b_sign;
        small_s   = a_big ? sub_b_sign : a_reg[15];
        diff      = big_e - small_e;
        small_ext = {small_m, 3'b000};
        if (diff >= 5'd14)
        begin
            aligned = 14'd0;
            lost    = small_m != 11'd0;
        end
        else
        begin
            aligned = small_ext >> diff[3:0];
            lost    = |(small_ext & ((14'd1 << diff[3:0]) - 14'd1));
        end

        a_lz     = lead_zeros11(a_man);
        b_lz     = lead_zeros11(b_man);
        a_norm   = a_man << a_lz;
        b_norm   = b_man << b_lz;
        div_expo = $signed({3'b000, a_eff}) - $signed({4'b0000, a_lz})
                 - $signed({3'b000, b_eff}) + $signed({4'b0000, b_lz}) + 8'sd15;
    end

    always_comb
    begin
        if (add_reg)
        begin
            add_res = x_reg + {1'b0, y_reg};
        end
        else
        begin
            add_res = x_reg - {1'b0, y_reg} - {14'd0, sticky_reg};
        end
    end

    always_comb
    begin
        msb = msb_pos15(x_reg);
        lsh = 4'd13 - msb;
        if (msb == 4'd14)
        begin
            n_sig  = x_reg[14:1];
            n_st   = sticky_reg | x_reg[0];
            n_expo = expo_reg + 8'sd1;
            lsh    = 4'd0;
        end
        else
        begin
            n_sig  = x_reg[13:0] << lsh;
            n_st   = sticky_reg;
            n_expo = expo_reg - $signed({4'b0000, lsh});
        end
    end

    always_comb
    begin
        r0   = x_reg[11:0];
        bit1 = r0 >= {1'b0, y_reg[10:0]};
        t1   = bit1 ? r0 - {1'b0, y_reg[10:0]} : r0;
        r1   = {t1[10:0], 1'b0};
        bit2 = r1 >= {1'b0, y_reg[10:0]};
        t2   = bit2 ? r1 - {1'b0, y_reg[10:0]} : r1;
        r2   = {t2[10:0], 1'b0};
    end

    always_comb
    begin
        if (q_reg[15])
        begin
            d_sig  = q_reg[15:2];
            d_st   = (|q_reg[1:0]) | (x_reg[11:0] != 12'd0);
            d_expo = expo_reg;
        end
        else
        begin
            d_sig  = q_reg[14:1];
            d_st   = q_reg[0] | (x_reg[11:0] != 12'd0);
            d_expo = expo_reg - 8'sd1;
        end
    end

    assign pop_ready = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign y_value   = y_value_reg;
    assign row_end   = row_end_reg;
    assign task_end  = task_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        a_reg     <= pop_item.a_value;
                        b_reg     <= pop_item.b_value;
                        op_reg    <= pop_item.op;
                        rend_reg  <= pop_item.row_end;
                        tend_reg  <= pop_item.task_end;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (prep_special)
                    begin
                        result_reg <= prep_value;
                        state_reg  <= ST_OUT;
                    end
                    else if (op_reg == OP_SUB)
                    begin
                        x_reg      <= {1'b0, big_m, 3'b000};
                        y_reg      <= aligned;
                        sticky_reg <= lost;
                        expo_reg   <= $signed({3'b000, big_e});
                        sign_reg   <= big_s;
                        add_reg    <= big_s == small_s;
                        state_reg  <= ST_ADD;
                    end
                    else
                    begin
                        x_reg      <= {4'd0, a_norm};
                        y_reg      <= {3'd0, b_norm};
                        expo_reg   <= div_expo;
                        sign_reg   <= div_sign;
                        q_reg      <= 16'd0;
                        cnt_reg    <= 3'd0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_ADD:
                begin
                    if (add_res == 15'd0)
                    begin
                        result_reg <= {add_reg & sign_reg, 15'd0};
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        x_reg      <= add_res;
                        state_reg  <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    x_reg      <= {1'b0, n_sig};
                    expo_reg   <= n_expo;
                    sticky_reg <= n_st;
                    state_reg  <= ST_ROUND;
                end
                ST_DIV:
                begin
                    x_reg   <= {3'd0, r2};
                    q_reg   <= {q_reg[13:0], bit1, bit2};
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_reg <= ST_DIVN;
                    end
                end
                ST_DIVN:
                begin
                    x_reg      <= {1'b0, d_sig};
                    expo_reg   <= d_expo;
                    sticky_reg <= d_st;
                    state_reg  <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    result_reg <= round_fp16(sign_reg, expo_reg, x_reg[13:0], sticky_reg);
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        y_value_reg   <= result_reg;
                        row_end_reg   <= rend_reg;
                        task_end_reg  <= tend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/fp16_broadcast_sub_div.sv =====
// Streaming binary16 subtract or divide over a row-major task.
// The input channel (in_valid, in_ready) carries a_value and b_value; each
// transfer yields exactly one transfer on the output channel (out_valid,
// out_ready) with y_value, row_end and task_end, in order.
// The configuration port writes opcode, broadcast_mode, row_length and
// row_count on cfg_write_en; the user must see that it is used only while
// the block is idle, as the block has no check. The front stage tracks row
// and column position and picks the broadcast scalar, then hands it to the
// arithmetic unit through a short queue, so the input keeps accepting while
// a result waits. Special operands (NaN, infinity, division by zero or of
// zero) go from PREP straight to OUT; an exact zero difference goes PREP,
// ADD, OUT; subtraction goes PREP, ADD, NORM, ROUND, OUT; division goes
// PREP, DIV, DIVN, ROUND, OUT. The arithmetic unit takes one element at a
// time; division retires two quotient bits per cycle in DIV.
// When the receiver stalls, the result is held on the outputs, the unit
// stops after finishing one more element, and the queue fills before
// in_ready drops. Reset clears the counters, the queue and the output valid,
// and returns the registers to subtract, elementwise, one by one.
module fp16_broadcast_sub_div
    import fbsd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] a_value,
    input  logic [15:0] b_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] y_value,
    output logic        row_end,
    output logic        task_end
);

    item_t       push_item;
    item_t       pop_item;
    logic        push_valid;
    logic        push_ready;
    logic        pop_valid;
    logic        pop_ready;
    logic        y_is_nan;
    logic        out_stall;
    logic [17:0] out_word;

    assign y_is_nan  = (y_value[14:10] == 5'h1F) && (y_value[9:0] != 10'd0);
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {y_value, row_end, task_end};

    fbsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .a_value      (a_value),
        .b_value      (b_value),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    fbsd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fbsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .y_value   (y_value),
        .row_end   (row_end),
        .task_end  (task_end)
    );

`include "fp16_broadcast_sub_div_macros.svh"

    `FBSD_ASSERT_SAME(a_task_end_row_end, out_valid && task_end, row_end, "task end without row end")
    `FBSD_ASSERT_SAME(a_qnan, out_valid && y_is_nan, y_value == QNAN16, "non-canonical NaN")
    `FBSD_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(out_word), "result not held")

endmodule
